// ===== sv/abdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Anchor box delta decode package
// Shared widths, reset values, register codes, the pipeline control bundle
// and the constant function that builds the exp mantissa table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abdd_pkg;

    localparam int EXP_TABLE_DEPTH = 256;

    localparam int COORD_W    = 18;
    localparam int DELTA_W    = 16;
    localparam int SCORE_W    = 16;
    localparam int BOX_W      = 17;
    localparam int IMG_W      = 14;
    localparam int MIN_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int LIMIT_W    = 20;
    localparam int MANT_W     = 17;

    localparam int PIPE_STAGES = 6;

    localparam logic [IMG_W-1:0] IMAGE_SIZE_RESET = 14'd1024;
    localparam logic [MIN_W-1:0] MIN_BOX_RESET    = 17'd256;

    localparam logic signed [LIMIT_W-1:0] COORD_MAX = 20'sd131071;

    localparam logic signed [21:0] LOG2E_Q20 = 22'sd1512775;
    localparam logic [63:0]        LN2_Q30   = 64'd744261118;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_HEIGHT = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_MIN_BOX_SIZE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic ld_s1;
        logic ld_s2;
        logic ld_s3;
        logic ld_s4;
        logic ld_s5;
        logic ld_s6;
    } abdd_ctl_t;

    // Returns round(2^f * 2^16) where x = f * ln2 in Q.30, from a 21 term series.
    function automatic logic [MANT_W-1:0] exp_rom_entry(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rounded;
        term = 64'd1 << 30;
        sum  = term;
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * x) >> 30) / 64'(k);
            sum  = sum + term;
        end
        rounded = (sum + (64'd1 << 13)) >> 14;
        return rounded[MANT_W-1:0];
    endfunction

endpackage

// ===== sv/anchor_box_delta_decode.sv =====
// ----------------------------------------------------------------------------
// Anchor box delta decode
// A result passes through the pipeline stages and then the output register.
// Throughput: one transaction per cycle; the x and y axis pipelines run side
// by side and a stall holds only the stages that are full behind it.
// Reset clears all valid bits and loads the default image size and minimum
// box size; the exp table is constant logic and needs no fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anchor_box_delta_decode #(
    parameter int EXP_TABLE_DEPTH = abdd_pkg::EXP_TABLE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [abdd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [abdd_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [abdd_pkg::COORD_W-1:0]    anchor_x1,
    input  logic signed [abdd_pkg::COORD_W-1:0]    anchor_y1,
    input  logic signed [abdd_pkg::COORD_W-1:0]    anchor_x2,
    input  logic signed [abdd_pkg::COORD_W-1:0]    anchor_y2,
    input  logic signed [abdd_pkg::DELTA_W-1:0]    delta_cx,
    input  logic signed [abdd_pkg::DELTA_W-1:0]    delta_cy,
    input  logic signed [abdd_pkg::DELTA_W-1:0]    delta_lw,
    input  logic signed [abdd_pkg::DELTA_W-1:0]    delta_lh,
    input  logic        [abdd_pkg::SCORE_W-1:0]    score_in,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic        [abdd_pkg::BOX_W-1:0]      box_x1,
    output logic        [abdd_pkg::BOX_W-1:0]      box_y1,
    output logic        [abdd_pkg::BOX_W-1:0]      box_x2,
    output logic        [abdd_pkg::BOX_W-1:0]      box_y2,
    output logic        [abdd_pkg::SCORE_W-1:0]    score_out
);

    localparam int STAGES = abdd_pkg::PIPE_STAGES;
    localparam int DIFF_W = abdd_pkg::BOX_W + 2;

    function automatic logic signed [abdd_pkg::LIMIT_W-1:0] clip_limit(
        input logic [abdd_pkg::IMG_W-1:0] pixels
    );
        logic signed [abdd_pkg::LIMIT_W-1:0] last;
        logic signed [abdd_pkg::LIMIT_W-1:0] lim;
        last = abdd_pkg::LIMIT_W'(pixels) - 20'sd1;
        lim  = last <<< 4;
        if (lim > abdd_pkg::COORD_MAX)
        begin
            lim = abdd_pkg::COORD_MAX;
        end
        return lim;
    endfunction

    logic [abdd_pkg::IMG_W-1:0] image_height_reg;
    logic [abdd_pkg::IMG_W-1:0] image_width_reg;
    logic [abdd_pkg::MIN_W-1:0] min_box_size_reg;

    logic signed [abdd_pkg::LIMIT_W-1:0] clip_x_hi;
    logic signed [abdd_pkg::LIMIT_W-1:0] clip_y_hi;

    logic [STAGES-1:0]         stage_valid_reg;
    logic [STAGES-1:0]         stage_ld;
    logic                      out_ld;
    abdd_pkg::abdd_ctl_t       ctl;

    logic [abdd_pkg::SCORE_W-1:0] score_pipe_reg [STAGES];

    logic [abdd_pkg::BOX_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [DIFF_W-1:0]   x_side, y_side;
    logic                       keep_box;
    logic                       out_valid_next;

    logic                       out_valid_reg;
    logic [abdd_pkg::BOX_W-1:0] box_x1_reg, box_y1_reg, box_x2_reg, box_y2_reg;
    logic [abdd_pkg::SCORE_W-1:0] score_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_height_reg <= abdd_pkg::IMAGE_SIZE_RESET;
            image_width_reg  <= abdd_pkg::IMAGE_SIZE_RESET;
            min_box_size_reg <= abdd_pkg::MIN_BOX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (abdd_pkg::cfg_reg_t'(cfg_index))
                abdd_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[abdd_pkg::IMG_W-1:0];
                abdd_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[abdd_pkg::IMG_W-1:0];
                abdd_pkg::CFG_MIN_BOX_SIZE: min_box_size_reg <= cfg_data[abdd_pkg::MIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign clip_x_hi = clip_limit(image_width_reg);
    assign clip_y_hi = clip_limit(image_height_reg);

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb
    begin
        out_ld = !out_valid_reg || !out_stall;
        stage_ld[STAGES-1] = !stage_valid_reg[STAGES-1] || out_ld;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ld[k] = !stage_valid_reg[k] || stage_ld[k+1];
        end
    end

    assign in_stall = !stage_ld[0];

    assign ctl.ld_s1 = stage_ld[0];
    assign ctl.ld_s2 = stage_ld[1];
    assign ctl.ld_s3 = stage_ld[2];
    assign ctl.ld_s4 = stage_ld[3];
    assign ctl.ld_s5 = stage_ld[4];
    assign ctl.ld_s6 = stage_ld[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            if (stage_ld[0])
            begin
                stage_valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (stage_ld[k])
                begin
                    stage_valid_reg[k] <= stage_valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[0])
        begin
            score_pipe_reg[0] <= score_in;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (stage_ld[k])
            begin
                score_pipe_reg[k] <= score_pipe_reg[k-1];
            end
        end
    end

    abdd_axis #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_axis_x (
        .clk     (clk),
        .ctl     (ctl),
        .c1      (anchor_x1),
        .c2      (anchor_x2),
        .dc      (delta_cx),
        .dl      (delta_lw),
        .clip_hi (clip_x_hi),
        .lo      (x_lo),
        .hi      (x_hi)
    );

    abdd_axis #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_axis_y (
        .clk     (clk),
        .ctl     (ctl),
        .c1      (anchor_y1),
        .c2      (anchor_y2),
        .dc      (delta_cy),
        .dl      (delta_lh),
        .clip_hi (clip_y_hi),
        .lo      (y_lo),
        .hi      (y_hi)
    );

    // Boxes with a clipped side below the minimum produce no transaction.
    always_comb
    begin
        x_side = $signed({2'b00, x_hi}) - $signed({2'b00, x_lo}) + 19'sd16;
        y_side = $signed({2'b00, y_hi}) - $signed({2'b00, y_lo}) + 19'sd16;
        keep_box = (x_side >= $signed({2'b00, min_box_size_reg}))
                && (y_side >= $signed({2'b00, min_box_size_reg}));
        out_valid_next = stage_valid_reg[STAGES-1] && keep_box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ld)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            box_x1_reg    <= x_lo;
            box_x2_reg    <= x_hi;
            box_y1_reg    <= y_lo;
            box_y2_reg    <= y_hi;
            score_out_reg <= score_pipe_reg[STAGES-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign box_x1    = box_x1_reg;
    assign box_y1    = box_y1_reg;
    assign box_x2    = box_x2_reg;
    assign box_y2    = box_y2_reg;
    assign score_out = score_out_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&stage_valid_reg) && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline has a free stage");

    a_accept_enters_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_valid_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_result_from_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg[STAGES-1]))
        else $error("result appeared without a transaction in the last stage");
`endif

endmodule

// ===== sv/abdd_axis.sv =====
// ----------------------------------------------------------------------------
// Anchor box delta decode, one axis
// Six-stage pipeline that turns one anchor edge pair and its two deltas into
// the two clipped box corners of that axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abdd_axis #(
    parameter int EXP_TABLE_DEPTH = abdd_pkg::EXP_TABLE_DEPTH
) (
    input  logic                                   clk,
    input  abdd_pkg::abdd_ctl_t                    ctl,
    input  logic signed [abdd_pkg::COORD_W-1:0]    c1,
    input  logic signed [abdd_pkg::COORD_W-1:0]    c2,
    input  logic signed [abdd_pkg::DELTA_W-1:0]    dc,
    input  logic signed [abdd_pkg::DELTA_W-1:0]    dl,
    input  logic signed [abdd_pkg::LIMIT_W-1:0]    clip_hi,
    output logic        [abdd_pkg::BOX_W-1:0]      lo,
    output logic        [abdd_pkg::BOX_W-1:0]      hi
);

    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
    localparam int FPROD_W = 32 + IDX_W;
    localparam int SIZE_W  = 20;
    localparam int CTR_W   = 21;
    localparam int T_W     = 37;
    localparam int SPROD_W = 36;
    localparam int PC_W    = 26;
    localparam int PROD_W  = 37;
    localparam int RND_W   = 38;
    localparam int HALF_W  = 24;
    localparam int CORN_W  = 27;

    localparam logic signed [RND_W-1:0] HALF_MAX = 38'sd8388607;
    localparam logic signed [RND_W-1:0] HALF_MIN = -38'sd8388608;

    function automatic logic [abdd_pkg::BOX_W-1:0] clip_coord(
        input logic signed [PC_W-1:0]              v,
        input logic signed [abdd_pkg::LIMIT_W-1:0] lim
    );
        logic signed [PC_W-1:0] lim_ext;
        logic signed [PC_W-1:0] r;
        lim_ext = PC_W'(lim);
        r = v;
        if (r > lim_ext)
        begin
            r = lim_ext;
        end
        if (r[PC_W-1])
        begin
            r = '0;
        end
        return r[abdd_pkg::BOX_W-1:0];
    endfunction

    logic [abdd_pkg::MANT_W-1:0] exp_rom [EXP_TABLE_DEPTH];

    for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam logic [63:0] ROM_X =
            (64'(gi) * abdd_pkg::LN2_Q30) / 64'(EXP_TABLE_DEPTH);
        assign exp_rom[gi] = abdd_pkg::exp_rom_entry(ROM_X);
    end

    // Stage 1: size, doubled centre, log2 of the scale.
    logic signed [SIZE_W-1:0]           s1_size_next, s1_size_reg;
    logic signed [CTR_W-1:0]            s1_ctr_next, s1_ctr_reg;
    logic signed [T_W-1:0]              s1_t_next, s1_t_reg;
    logic signed [abdd_pkg::DELTA_W-1:0] s1_dc_reg;

    // Stage 2: centre shift product, table index, exponent.
    logic signed [SPROD_W-1:0] s2_sprod_next, s2_sprod_reg;
    logic [FPROD_W-1:0]        s2_fprod;
    logic [IDX_W-1:0]          s2_idx_next, s2_idx_reg;
    logic signed [4:0]         s2_n_reg;
    logic signed [SIZE_W-1:0]  s2_size_reg;
    logic signed [CTR_W-1:0]   s2_ctr_reg;

    // Stage 3: table read, shifted centre.
    logic signed [SPROD_W-1:0]    s3_sround;
    logic signed [24:0]           s3_shift;
    logic signed [PC_W-1:0]       s3_pc_next, s3_pc_reg;
    logic [abdd_pkg::MANT_W-1:0]  s3_mant_reg;
    logic signed [4:0]            s3_n_reg;
    logic signed [SIZE_W-1:0]     s3_size_reg;

    // Stage 4: scaled size product and shift amount.
    logic signed [PROD_W-1:0] s4_prod_next, s4_prod_reg;
    logic [4:0]               s4_shamt_next, s4_shamt_reg;
    logic signed [PC_W-1:0]   s4_pc_reg;

    // Stage 5: rounded and saturated half size.
    logic signed [RND_W-1:0]  s5_round;
    logic signed [RND_W-1:0]  s5_shifted;
    logic signed [HALF_W-1:0] s5_half_next, s5_half_reg;
    logic signed [PC_W-1:0]   s5_pc_reg;

    // Stage 6: corners, rounded to Q.4 and clipped.
    logic signed [CORN_W-1:0]     s6_lo_sum, s6_hi_sum;
    logic [abdd_pkg::BOX_W-1:0]   s6_lo_next, s6_lo_reg;
    logic [abdd_pkg::BOX_W-1:0]   s6_hi_next, s6_hi_reg;

    always_comb
    begin
        s1_size_next = SIZE_W'(c2) - SIZE_W'(c1) + 20'sd16;
        s1_ctr_next  = CTR_W'(c1) + CTR_W'(c1) + CTR_W'(s1_size_next);
        s1_t_next    = T_W'(dl) * T_W'(abdd_pkg::LOG2E_Q20);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_s1)
        begin
            s1_size_reg <= s1_size_next;
            s1_ctr_reg  <= s1_ctr_next;
            s1_t_reg    <= s1_t_next;
            s1_dc_reg   <= dc;
        end
    end

    always_comb
    begin
        s2_sprod_next = SPROD_W'(s1_dc_reg) * SPROD_W'(s1_size_reg);
        s2_fprod      = FPROD_W'(s1_t_reg[31:0]) * FPROD_W'(EXP_TABLE_DEPTH);
        s2_idx_next   = s2_fprod[FPROD_W-1:32];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_s2)
        begin
            s2_sprod_reg <= s2_sprod_next;
            s2_idx_reg   <= s2_idx_next;
            s2_n_reg     <= s1_t_reg[T_W-1:32];
            s2_size_reg  <= s1_size_reg;
            s2_ctr_reg   <= s1_ctr_reg;
        end
    end

    always_comb
    begin
        s3_sround  = s2_sprod_reg + 36'sd1024;
        s3_shift   = $signed(s3_sround[SPROD_W-1:11]);
        s3_pc_next = PC_W'(s2_ctr_reg) + PC_W'(s3_shift);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_s3)
        begin
            s3_mant_reg <= exp_rom[s2_idx_reg];
            s3_pc_reg   <= s3_pc_next;
            s3_n_reg    <= s2_n_reg;
            s3_size_reg <= s2_size_reg;
        end
    end

    always_comb
    begin
        s4_prod_next  = PROD_W'(s3_size_reg) * PROD_W'($signed({1'b0, s3_mant_reg}));
        s4_shamt_next = 5'd16 - s3_n_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_s4)
        begin
            s4_prod_reg  <= s4_prod_next;
            s4_shamt_reg <= s4_shamt_next;
            s4_pc_reg    <= s3_pc_reg;
        end
    end

    always_comb
    begin
        s5_round   = RND_W'(s4_prod_reg) + (38'sd1 <<< (s4_shamt_reg - 5'd1));
        s5_shifted = s5_round >>> s4_shamt_reg;
        if (s5_shifted > HALF_MAX)
        begin
            s5_half_next = HALF_MAX[HALF_W-1:0];
        end
        else if (s5_shifted < HALF_MIN)
        begin
            s5_half_next = HALF_MIN[HALF_W-1:0];
        end
        else
        begin
            s5_half_next = s5_shifted[HALF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_s5)
        begin
            s5_half_reg <= s5_half_next;
            s5_pc_reg   <= s4_pc_reg;
        end
    end

    always_comb
    begin
        s6_lo_sum  = CORN_W'(s5_pc_reg) - CORN_W'(s5_half_reg) + 27'sd1;
        s6_hi_sum  = CORN_W'(s5_pc_reg) + CORN_W'(s5_half_reg) + 27'sd1;
        s6_lo_next = clip_coord($signed(s6_lo_sum[CORN_W-1:1]), clip_hi);
        s6_hi_next = clip_coord($signed(s6_hi_sum[CORN_W-1:1]), clip_hi);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_s6)
        begin
            s6_lo_reg <= s6_lo_next;
            s6_hi_reg <= s6_hi_next;
        end
    end

    assign lo = s6_lo_reg;
    assign hi = s6_hi_reg;

endmodule
